// ===== rtl/ascd_pkg.sv =====
package ascd_pkg;

    // Field widths
    localparam int SAMPLE_W    = 15;
    localparam int COEF_W      = 16;
    localparam int WLEN_W      = 9;
    localparam int THR_W       = 16;
    localparam int ERR_W       = 16;
    localparam int SUM_OUT_W   = 24;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Fixed-point arithmetic
    localparam int FRAC_W     = 14;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int DIFF_W     = 20;
    localparam int ROUND_BIAS = 1 << (FRAC_W - 1);

    // Defaults
    localparam int WINDOW_MAX_DEF  = 256;
    localparam int INDEX_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [COEF_W-1:0]    COEF_RESET  = 16'h8000;
    localparam logic [WLEN_W-1:0]    WLEN_RESET  = 9'd50;
    localparam logic [THR_W-1:0]     THR_RESET   = 16'd983;
    localparam logic [ERR_W-1:0]     ERR_MAX     = '1;
    localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = '1;

    // Configuration register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEFFICIENT   = 2'd0,
        CFG_WINDOW_LENGTH = 2'd1,
        CFG_THRESHOLD     = 2'd2
    } cfg_index_t;

    // Item handed from the front to the back
    typedef struct packed {
        logic signed [PROD_W-1:0]   product;
        logic signed [SAMPLE_W-1:0] older;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        logic                       last;
    } mid_item_t;

endpackage

// ===== rtl/ascd_fifo.sv =====
module ascd_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = ascd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ascd_front.sv =====
module ascd_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    clear_rec,
    input  logic signed [ascd_pkg::COEF_W-1:0]      coefficient,
    input  logic                                    push,
    input  logic signed [ascd_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                    last_sample,
    input  logic                                    q_full,
    output logic                                    q_push,
    output ascd_pkg::mid_item_t                     q_item
);

    localparam int PROD_W = ascd_pkg::PROD_W;

    logic signed [ascd_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [ascd_pkg::SAMPLE_W-1:0] older_reg, older_next;
    logic                                 first_reg, first_next;
    logic                                 accept;

    assign accept = push && !q_full;
    assign q_push = push;

    // Resonator product a1 * y[n-1]; registered in the queue
    always_comb
    begin
        q_item.product = PROD_W'(coefficient) * PROD_W'(prev_reg);
        q_item.older   = older_reg;
        q_item.sample  = sample;
        q_item.first   = first_reg;
        q_item.last    = last_sample;
    end

    // Sample history; a record end or a window_length write restarts it
    always_comb
    begin
        prev_next  = prev_reg;
        older_next = older_reg;
        first_next = first_reg;
        if (clear_rec)
        begin
            prev_next  = '0;
            older_next = '0;
            first_next = 1'b1;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                prev_next  = '0;
                older_next = '0;
                first_next = 1'b1;
            end
            else
            begin
                prev_next  = sample;
                older_next = prev_reg;
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            older_reg <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            prev_reg  <= prev_next;
            older_reg <= older_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== rtl/ascd_back.sv =====
module ascd_back #(
    parameter int WINDOW_MAX  = ascd_pkg::WINDOW_MAX_DEF,
    parameter int INDEX_WIDTH = ascd_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clear_rec,
    input  logic [$clog2(WINDOW_MAX + 1)-1:0]     len,
    input  logic [ascd_pkg::THR_W + $clog2(WINDOW_MAX + 1)-1:0] thr_len,
    input  logic                                  q_empty,
    input  ascd_pkg::mid_item_t                   q_item,
    output logic                                  q_pop,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [ascd_pkg::ERR_W-1:0]            error_magnitude,
    output logic                                  window_valid,
    output logic [ascd_pkg::SUM_OUT_W-1:0]        window_sum,
    output logic                                  below_threshold,
    output logic [INDEX_WIDTH-1:0]                center_index,
    output logic                                  border_found,
    output logic [INDEX_WIDTH-1:0]                first_border,
    output logic [INDEX_WIDTH-1:0]                last_border,
    output logic                                  record_end
);

    localparam int PROD_W    = ascd_pkg::PROD_W;
    localparam int DIFF_W    = ascd_pkg::DIFF_W;
    localparam int ERR_W     = ascd_pkg::ERR_W;
    localparam int SUM_OUT_W = ascd_pkg::SUM_OUT_W;
    localparam int PTR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W     = ERR_W + PTR_W;
    localparam int IW        = INDEX_WIDTH;
    localparam int RES_W     = ERR_W + 1 + SUM_OUT_W + 1 + 3 * IW + 1 + 1;
    localparam logic signed [PROD_W-1:0] BIAS_S = PROD_W'(ascd_pkg::ROUND_BIAS);

    // Error from the queue head
    logic signed [PROD_W-1:0] biased, rounded;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [ERR_W-1:0]         err;

    always_comb
    begin
        biased  = q_item.product + BIAS_S;
        rounded = biased >>> ascd_pkg::FRAC_W;
        diff    = -DIFF_W'(rounded) - DIFF_W'(q_item.older) - DIFF_W'(q_item.sample);
        mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        if (q_item.first)
        begin
            err = '0;
        end
        else if (mag > DIFF_W'(ascd_pkg::ERR_MAX))
        begin
            err = ascd_pkg::ERR_MAX;
        end
        else
        begin
            err = mag[ERR_W-1:0];
        end
    end

    // Window stage handshake
    logic             b1_valid_reg;
    logic [ERR_W-1:0] b1_err_reg;
    logic             b1_last_reg;
    logic [PTR_W-1:0] b1_pos_reg;
    logic             b1_go;
    logic             res_full;
    logic [PTR_W-1:0] rd_pos_reg, rd_pos_next;

    assign b1_go = b1_valid_reg && !res_full;
    assign q_pop = !q_empty && (!b1_valid_reg || b1_go);

    // Ring read pointer, advanced as items enter the window stage
    always_comb
    begin
        rd_pos_next = rd_pos_reg;
        if (clear_rec)
        begin
            rd_pos_next = '0;
        end
        else if (q_pop)
        begin
            if (q_item.last || (LEN_W'(rd_pos_reg) + LEN_W'(1) >= len))
            begin
                rd_pos_next = '0;
            end
            else
            begin
                rd_pos_next = rd_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pos_reg   <= '0;
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pos_reg <= rd_pos_next;
            if (q_pop)
            begin
                b1_valid_reg <= 1'b1;
            end
            else if (b1_go)
            begin
                b1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_err_reg  <= err;
            b1_last_reg <= q_item.last;
            b1_pos_reg  <= rd_pos_reg;
        end
    end

    // Error ring: read as an item enters, written as it leaves
    logic [ERR_W-1:0] ring_mem [WINDOW_MAX];
    logic [ERR_W-1:0] ring_rd_reg;

    always_ff @(posedge clk)
    begin
        if (b1_go)
        begin
            ring_mem[b1_pos_reg] <= b1_err_reg;
        end
        if (q_pop)
        begin
            ring_rd_reg <= ring_mem[rd_pos_reg];
        end
    end

    // Record state
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [IW-1:0]    index_reg, index_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    first_reg, first_next;
    logic [IW-1:0]    lastc_reg, lastc_next;

    logic                 full_before;
    logic [SUM_W-1:0]     sum_calc;
    logic [LEN_W-1:0]     fill_calc;
    logic                 valid;
    logic [31:0]          sum_ext;
    logic [SUM_OUT_W-1:0] sum_sat;
    logic                 below;
    logic [IW-1:0]        center;
    logic                 found_calc;
    logic [IW-1:0]        first_calc, lastc_calc;

    // Window sum, threshold test and border tracking
    always_comb
    begin
        full_before = (fill_reg >= len);
        sum_calc    = sum_reg - (full_before ? SUM_W'(ring_rd_reg) : '0) + SUM_W'(b1_err_reg);
        fill_calc   = full_before ? fill_reg : fill_reg + 1'b1;
        valid       = (fill_calc >= len);
        sum_ext     = 32'(sum_calc);
        sum_sat     = (sum_ext > 32'(ascd_pkg::SUM_OUT_MAX)) ? ascd_pkg::SUM_OUT_MAX
                                                             : sum_ext[SUM_OUT_W-1:0];
        below       = valid && (32'(sum_sat) <= 32'(thr_len));
        center      = valid ? IW'(32'(index_reg) + 32'd1 - 32'(len >> 1)) : '0;
        found_calc  = found_reg || below;
        first_calc  = (below && !found_reg) ? center : first_reg;
        lastc_calc  = below ? center : lastc_reg;
    end

    always_comb
    begin
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        index_next = index_reg;
        found_next = found_reg;
        first_next = first_reg;
        lastc_next = lastc_reg;
        if (clear_rec || (b1_go && b1_last_reg))
        begin
            sum_next   = '0;
            fill_next  = '0;
            index_next = '0;
            found_next = 1'b0;
            first_next = '0;
            lastc_next = '0;
        end
        else if (b1_go)
        begin
            sum_next   = sum_calc;
            fill_next  = fill_calc;
            index_next = index_reg + 1'b1;
            found_next = found_calc;
            first_next = first_calc;
            lastc_next = lastc_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            fill_reg  <= '0;
            index_reg <= '0;
            found_reg <= 1'b0;
            first_reg <= '0;
            lastc_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            index_reg <= index_next;
            found_reg <= found_next;
            first_reg <= first_next;
            lastc_reg <= lastc_next;
        end
    end

    // Result queue
    logic [RES_W-1:0] res_in, res_out;

    assign res_in = {b1_err_reg, valid, sum_sat, below, center,
                     found_calc, first_calc, lastc_calc, b1_last_reg};

    ascd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ascd_pkg::QUEUE_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (b1_go),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign {error_magnitude, window_valid, window_sum, below_threshold, center_index,
            border_found, first_border, last_border, record_end} = res_out;

endmodule

// ===== rtl/ar2_sinusoid_change_detector.sv =====
// Second-order prediction error detector. Each item carries one Q1.14 sample;
// the block predicts it with the resonator -a1*y[n-1] - y[n-2], reports the
// magnitude of the prediction error, and keeps a sliding window of the last
// window_length errors (even, 2 to WINDOW_MAX). When a full window's sum is at
// or below threshold*window_length the window centre is marked, and the first
// and last such centres of the record are reported. The item flagged
// last_sample closes the record and clears record state; writing
// window_length does the same. The block sustains one item per clock while
// the result queue has room: the front does the one resonator multiply, the
// back reads the error ring as an item enters the window stage, ahead of
// the running-sum update, and results wait in the output queue. The error
// ring needs no clearing pass after reset. cfg_ready is always high; write
// configuration only while no items are in flight.
module ar2_sinusoid_change_detector #(
    parameter int WINDOW_MAX  = ascd_pkg::WINDOW_MAX_DEF,
    parameter int INDEX_WIDTH = ascd_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Sample queue
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [ascd_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   last_sample,
    // Result queue
    output logic                                   empty,
    input  logic                                   pop,
    output logic [ascd_pkg::ERR_W-1:0]             error_magnitude,
    output logic                                   window_valid,
    output logic [ascd_pkg::SUM_OUT_W-1:0]         window_sum,
    output logic                                   below_threshold,
    output logic [INDEX_WIDTH-1:0]                 center_index,
    output logic                                   border_found,
    output logic [INDEX_WIDTH-1:0]                 first_border,
    output logic [INDEX_WIDTH-1:0]                 last_border,
    output logic                                   record_end,
    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ascd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ascd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int THR_LEN_W = ascd_pkg::THR_W + LEN_W;
    localparam int LEN_CAP   = (WINDOW_MAX / 2) * 2;
    localparam int MID_W     = $bits(ascd_pkg::mid_item_t);

    // Configuration registers
    logic [ascd_pkg::COEF_W-1:0] coefficient_reg;
    logic [ascd_pkg::WLEN_W-1:0] window_length_reg;
    logic [ascd_pkg::THR_W-1:0]  threshold_reg;
    logic                        cfg_write;
    logic                        clear_rec;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign clear_rec = cfg_write && (cfg_index == ascd_pkg::CFG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefficient_reg   <= ascd_pkg::COEF_RESET;
            window_length_reg <= ascd_pkg::WLEN_RESET;
            threshold_reg     <= ascd_pkg::THR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ascd_pkg::CFG_COEFFICIENT:
                begin
                    coefficient_reg <= cfg_data[ascd_pkg::COEF_W-1:0];
                end
                ascd_pkg::CFG_WINDOW_LENGTH:
                begin
                    window_length_reg <= cfg_data[ascd_pkg::WLEN_W-1:0];
                end
                ascd_pkg::CFG_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[ascd_pkg::THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Effective window length: even, clamped to 2..WINDOW_MAX
    logic [31:0]      len_tmp;
    logic [LEN_W-1:0] len;

    always_comb
    begin
        len_tmp = 32'({window_length_reg[ascd_pkg::WLEN_W-1:1], 1'b0});
        if (len_tmp < 32'd2)
        begin
            len_tmp = 32'd2;
        end
        else if (len_tmp > 32'(WINDOW_MAX))
        begin
            len_tmp = 32'(LEN_CAP);
        end
        len = LEN_W'(len_tmp);
    end

    // Threshold scaled by window length
    logic [THR_LEN_W-1:0] thr_len_reg;

    always_ff @(posedge clk)
    begin
        thr_len_reg <= THR_LEN_W'(threshold_reg) * THR_LEN_W'(len);
    end

    // Front, decoupling queue, back
    ascd_pkg::mid_item_t f_item, b_item;
    logic                q_push, q_pop, q_empty;
    logic [MID_W-1:0]    b_item_bits;

    ascd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_rec   (clear_rec),
        .coefficient (coefficient_reg),
        .push        (push),
        .sample      (sample),
        .last_sample (last_sample),
        .q_full      (full),
        .q_push      (q_push),
        .q_item      (f_item)
    );

    ascd_fifo #(
        .WIDTH (MID_W),
        .DEPTH (ascd_pkg::QUEUE_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (f_item),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (b_item_bits),
        .empty     (q_empty)
    );

    assign b_item = ascd_pkg::mid_item_t'(b_item_bits);

    ascd_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .clear_rec       (clear_rec),
        .len             (len),
        .thr_len         (thr_len_reg),
        .q_empty         (q_empty),
        .q_item          (b_item),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .error_magnitude (error_magnitude),
        .window_valid    (window_valid),
        .window_sum      (window_sum),
        .below_threshold (below_threshold),
        .center_index    (center_index),
        .border_found    (border_found),
        .first_border    (first_border),
        .last_border     (last_border),
        .record_end      (record_end)
    );

endmodule

// ===== rtl/ascd_checker.sv =====
module ascd_checker #(
    parameter int WINDOW_MAX  = ascd_pkg::WINDOW_MAX_DEF,
    parameter int INDEX_WIDTH = ascd_pkg::INDEX_WIDTH_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 empty,
    input logic                                 pop,
    input logic [ascd_pkg::ERR_W-1:0]           error_magnitude,
    input logic                                 window_valid,
    input logic [ascd_pkg::SUM_OUT_W-1:0]       window_sum,
    input logic                                 below_threshold,
    input logic [INDEX_WIDTH-1:0]               center_index,
    input logic                                 border_found,
    input logic [INDEX_WIDTH-1:0]               first_border,
    input logic [INDEX_WIDTH-1:0]               last_border,
    input logic                                 record_end
);

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(error_magnitude) && $stable(window_sum)
                           && $stable(center_index) && $stable(record_end))
        else $error("waiting result changed");

    // A window below threshold must be a full window; without one the centre index is zero
    a_below_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !window_valid |-> !below_threshold && center_index == '0)
        else $error("threshold flag or centre without a full window");

    // A window below threshold is a border and becomes the last border
    a_below_sets_border: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && below_threshold |-> border_found && last_border == center_index)
        else $error("border not tracked");

    // No border, no border indexes
    a_no_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !border_found |-> first_border == '0 && last_border == '0)
        else $error("border indexes without a border");

endmodule

bind ar2_sinusoid_change_detector ascd_checker #(
    .WINDOW_MAX  (WINDOW_MAX),
    .INDEX_WIDTH (INDEX_WIDTH)
) u_ascd_checker (.*);
